// ===== hw/rtl/knapsack_01_max_value_unit_defines.svh =====
// assertion macros shared by the knapsack rtl
// both expect clk and rst_n in the module that uses them
`ifndef KNAPSACK_01_MAX_VALUE_UNIT_DEFINES_SVH
`define KNAPSACK_01_MAX_VALUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold whenever reset is released
`define KN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen while reset is released
`define KN_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define KN_ASSERT(lbl, prop, msg)

`define KN_NEVER(lbl, cond, msg)

`endif

`endif

// ===== hw/rtl/kn01_pkg.sv =====
package kn01_pkg;

    localparam int VALUE_W     = 16;
    localparam int WEIGHT_W    = 10;
    localparam int CAP_W       = 10;
    localparam int TOTAL_W     = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    localparam int MAX_CAPACITY_DEF = 1023;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // control for one table update
    typedef struct packed {
        logic fit;    // item weight fits at this capacity
        logic fresh;  // table is logically all zeros
    } upd_ctrl_t;

endpackage

// ===== hw/rtl/kn01_ram.sv =====
module kn01_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] ra_addr,
    output logic [WIDTH-1:0]         ra_data,
    input  logic [$clog2(DEPTH)-1:0] rb_addr,
    output logic [WIDTH-1:0]         rb_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

// ===== hw/rtl/kn01_upd.sv =====
module kn01_upd (
    input  kn01_pkg::upd_ctrl_t             ctrl,
    input  logic [kn01_pkg::TOTAL_W-1:0]    old_total,
    input  logic [kn01_pkg::TOTAL_W-1:0]    base_total,
    input  logic [kn01_pkg::VALUE_W-1:0]    item_value,
    output logic [kn01_pkg::TOTAL_W-1:0]    new_total
);
    import kn01_pkg::*;

    logic [TOTAL_W-1:0] old_eff;
    logic [TOTAL_W-1:0] base_eff;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] take;

    // a fresh table reads as zero everywhere
    assign old_eff  = ctrl.fresh ? '0 : old_total;
    assign base_eff = ctrl.fresh ? '0 : base_total;

    assign sum  = {1'b0, base_eff} + {{(TOTAL_W + 1 - VALUE_W){1'b0}}, item_value};
    assign take = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

    always_comb
    begin
        new_total = old_eff;
        if (ctrl.fit && (take > old_eff))
        begin
            new_total = take;
        end
    end

endmodule

// ===== hw/rtl/knapsack_01_max_value_unit.sv =====
// 0/1 knapsack solver. Items (value, weight, last flag) arrive one at a time on the
// slave stream; each one sweeps a table of best totals, one entry per capacity
// from MAX_CAPACITY down to 0, through one read-modify-write per cycle on a
// two-read one-write ram and a single saturating add/compare unit. An item
// occupies the block from its accept through the sweep of all MAX_CAPACITY + 1
// entries and a drain state for the pipelined write; the final item of a set
// then loads the result in a wait state, which holds while the previous result
// has not yet been taken. The ram write port, one entry per cycle, paces the
// sweep. After a last item the best total at the capacity register (clamped
// to MAX_CAPACITY) is sent on the master stream. The table needs no clearing
// pass: after reset and after every last item it is marked fresh, and the next
// sweep treats every read as zero while it rewrites every entry. The capacity
// register may only be written while the block is idle.
`include "knapsack_01_max_value_unit_defines.svh"

module knapsack_01_max_value_unit #(
    parameter int MAX_CAPACITY = kn01_pkg::MAX_CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration: knapsack_capacity
    input  logic                                cfg_wr_en,
    input  logic [kn01_pkg::CAP_W-1:0]          cfg_wr_data,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] item_value, [25:16] item_weight, [31:26] zero
    input  logic [kn01_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,    // last_item
    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] best_total
    output logic [kn01_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import kn01_pkg::*;

    localparam int DEPTH  = MAX_CAPACITY + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = (ADDR_W > WEIGHT_W) ? ADDR_W : WEIGHT_W;

    localparam logic [ADDR_W-1:0] MAX_ADDR = ADDR_W'(MAX_CAPACITY);
    localparam logic [CMP_W-1:0]  MAX_CMP  = CMP_W'(MAX_CAPACITY);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;  // ready for an item
    localparam logic [1:0] ST_SWEEP = 2'd1;  // issuing table reads, high to low
    localparam logic [1:0] ST_DRAIN = 2'd2;  // last write of the sweep
    localparam logic [1:0] ST_WAIT  = 2'd3;  // result waits for the output slot

    logic [1:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                fresh_reg, fresh_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic                s1_valid_reg, s1_valid_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // payload registers, no reset
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic                last_reg, last_next;
    logic [ADDR_W-1:0]   s1_addr_reg, s1_addr_next;
    logic                s1_fit_reg, s1_fit_next;
    logic [TOTAL_W-1:0]  result_reg, result_next;
    logic [TOTAL_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [CMP_W-1:0]    addr_cmp;
    logic [CMP_W-1:0]    weight_cmp;
    logic [CMP_W-1:0]    cap_cmp;
    logic [ADDR_W-1:0]   cap_addr;
    logic                fit;
    logic [ADDR_W-1:0]   base_addr;
    logic [TOTAL_W-1:0]  old_total;
    logic [TOTAL_W-1:0]  base_total;
    logic [TOTAL_W-1:0]  new_total;
    upd_ctrl_t           upd_ctrl;
    logic                in_accept;
    logic                out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(m_tdata_reg);
    assign out_free      = !m_tvalid_reg || m_axis_tready;

    // item fits at the capacity being read
    assign addr_cmp   = CMP_W'(addr_reg);
    assign weight_cmp = CMP_W'(weight_reg);
    assign fit        = (weight_cmp <= addr_cmp);
    assign base_addr  = fit ? ADDR_W'(addr_cmp - weight_cmp) : addr_reg;

    // capacity above the table reads the top entry
    assign cap_cmp  = CMP_W'(cap_reg);
    assign cap_addr = ADDR_W'((cap_cmp > MAX_CMP) ? MAX_CMP : cap_cmp);

    // entries written in a sweep are always above the ones being read,
    // so the registered ram reads need no forwarding
    kn01_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (s1_valid_reg),
        .waddr   (s1_addr_reg),
        .wdata   (new_total),
        .ra_addr (addr_reg),
        .ra_data (old_total),
        .rb_addr (base_addr),
        .rb_data (base_total)
    );

    assign upd_ctrl.fit   = s1_fit_reg;
    assign upd_ctrl.fresh = fresh_reg;

    kn01_upd u_upd (
        .ctrl       (upd_ctrl),
        .old_total  (old_total),
        .base_total (base_total),
        .item_value (value_reg),
        .new_total  (new_total)
    );

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        fresh_next    = fresh_reg;
        cap_next      = cap_reg;
        m_tvalid_next = m_tvalid_reg;
        value_next    = value_reg;
        weight_next   = weight_reg;
        last_next     = last_reg;
        result_next   = result_reg;
        m_tdata_next  = m_tdata_reg;

        // read issued this cycle becomes the write of the next
        s1_valid_next = (state_reg == ST_SWEEP);
        s1_addr_next  = addr_reg;
        s1_fit_next   = fit;

        if (cfg_wr_en)
        begin
            cap_next = cfg_wr_data;
        end

        if (m_tvalid_reg && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // keep the new entry at the configured capacity
        if (s1_valid_reg && (s1_addr_reg == cap_addr))
        begin
            result_next = new_total;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    value_next  = s_axis_tdata[VALUE_W-1:0];
                    weight_next = s_axis_tdata[VALUE_W +: WEIGHT_W];
                    last_next   = s_axis_tlast;
                    addr_next   = MAX_ADDR;
                    state_next  = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (addr_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg - 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // a finished set leaves the table logically cleared
                fresh_next = last_reg;
                state_next = last_reg ? ST_WAIT : ST_IDLE;
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = result_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            addr_reg     <= '0;
            fresh_reg    <= 1'b1;
            cap_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            fresh_reg    <= fresh_next;
            cap_reg      <= cap_next;
            s1_valid_reg <= s1_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        weight_reg  <= weight_next;
        last_reg    <= last_next;
        s1_addr_reg <= s1_addr_next;
        s1_fit_reg  <= s1_fit_next;
        result_reg  <= result_next;
        m_tdata_reg <= m_tdata_next;
    end

    `KN_ASSERT(a_sweep_start, in_accept |=> (state_reg == ST_SWEEP) && (addr_reg == MAX_ADDR), "sweep must start at the top entry")
    `KN_ASSERT(a_drain_bottom, (state_reg == ST_DRAIN) |-> s1_valid_reg && (s1_addr_reg == '0), "drain must write the bottom entry")
    `KN_ASSERT(a_fresh_steady, (state_reg == ST_SWEEP) && $past(state_reg == ST_SWEEP) |-> $stable(fresh_reg), "fresh mark changed inside a sweep")
    `KN_ASSERT(a_result_source, $rose(m_tvalid_reg) |-> $past(state_reg == ST_WAIT && last_reg), "result shown without a finished set")
    `KN_NEVER(a_write_range, s1_valid_reg && (s1_addr_reg > MAX_ADDR), "table write beyond capacity range")

endmodule
